// ===== rtl/core/base64_stream_encoder_top_assert.svh =====
// assertion macros shared by the base64 stream encoder modules
// expects signals named clk and arst_n in the module that uses them
`ifndef BASE64_STREAM_ENCODER_TOP_ASSERT_SVH
`define BASE64_STREAM_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define B64E_ASSERT_IMPL(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is active
`define B64E_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/b64e_pkg.sv =====
// shared types, constants and the alphabet lookup for the base64 stream encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package b64e_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [6:0] PAD_CHAR   = 7'd61;
	localparam logic [6:0] CHAR_PLUS  = 7'd43;
	localparam logic [6:0] CHAR_SLASH = 7'd47;
	localparam logic [1:0] LAST_SLOT  = 2'd3;
	localparam logic [1:0] FULL_HOLD  = 2'd2;

	// one completed group: 24 bits msb-first and the number of real bytes (1..3)
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  nbytes;
	} grp_t;

	function automatic logic [6:0] sextet_char(input logic [5:0] s);
		logic [6:0] r;
		case (s) inside
			[6'd0:6'd25]:  r = 7'd65 + {1'b0, s};
			[6'd26:6'd51]: r = 7'd71 + {1'b0, s};
			[6'd52:6'd61]: r = {1'b0, s} - 7'd4;
			6'd62:         r = CHAR_PLUS;
			default:       r = CHAR_SLASH;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/b64e_front.sv =====
// front part: takes bytes, holds up to two, and pushes completed groups
// depends on b64e_pkg
`timescale 1ns / 1ps
`default_nettype none
module b64e_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [7:0]    s_tdata,
	input  wire logic          s_tlast,
	input  wire logic          q_full,
	output logic               push,
	output b64e_pkg::grp_t     push_grp
);

	logic [1:0] cnt_q;
	logic [7:0] held_q [0:1];
	logic       accept;
	logic       completes;

	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;
	assign completes = s_tlast || (cnt_q >= b64e_pkg::FULL_HOLD);
	assign push      = accept && completes;

	always_comb begin
		push_grp.nbytes = (cnt_q >= b64e_pkg::FULL_HOLD) ? 2'd3 : cnt_q + 2'd1;
		case (cnt_q)
			2'd0:    push_grp.bits = {s_tdata, 16'd0};
			2'd1:    push_grp.bits = {held_q[0], s_tdata, 8'd0};
			default: push_grp.bits = {held_q[0], held_q[1], s_tdata};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= completes ? 2'd0 : cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !completes) begin
			held_q[cnt_q[0]] <= s_tdata;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/b64e_fifo.sv =====
// short group queue between the front and the back
// depends on b64e_pkg and base64_stream_encoder_top_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "base64_stream_encoder_top_assert.svh"
module b64e_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire b64e_pkg::grp_t  push_grp,
	input  wire logic            pop,
	output b64e_pkg::grp_t       head,
	output logic                 full,
	output logic                 empty
);

	b64e_pkg::grp_t                   mem_q [0:b64e_pkg::QDEPTH-1];
	logic [b64e_pkg::QPTR_W-1:0]      wptr_q;
	logic [b64e_pkg::QPTR_W-1:0]      rptr_q;
	logic [b64e_pkg::QCNT_W-1:0]      count_q;

	assign full  = (count_q == b64e_pkg::QCNT_W'(b64e_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rptr_q];

	function automatic logic [b64e_pkg::QPTR_W-1:0] next_ptr(
		input logic [b64e_pkg::QPTR_W-1:0] p
	);
		logic [b64e_pkg::QPTR_W-1:0] r;
		if (p == b64e_pkg::QPTR_W'(b64e_pkg::QDEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= next_ptr(wptr_q);
			end
			if (pop) begin
				rptr_q <= next_ptr(rptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_grp;
		end
	end

	`B64E_ASSERT_IMPL(a_no_overflow, push && full, pop, "group pushed into a full queue")
	`B64E_ASSERT_IMPL(a_no_underflow, pop, !empty, "group popped from an empty queue")
	`B64E_ASSERT_IMPL(a_count_range, 1'b1, count_q <= b64e_pkg::QCNT_W'(b64e_pkg::QDEPTH),
		"queue count beyond depth")

endmodule
`default_nettype wire

// ===== rtl/core/b64e_back.sv =====
// back part: turns each queued group into four characters, one per cycle unless the output stalls
// depends on b64e_pkg and base64_stream_encoder_top_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "base64_stream_encoder_top_assert.svh"
module b64e_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire b64e_pkg::grp_t  head,
	input  wire logic            empty,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [7:0]           m_tdata,
	output logic                 m_tlast
);

	logic            busy_q;
	logic [1:0]      k_q;
	b64e_pkg::grp_t  grp_q;
	logic            m_tvalid_q;
	logic [6:0]      char_q;
	logic            last_q;

	logic            slot_free;
	logic            have;
	logic            fire;
	b64e_pkg::grp_t  cur;
	logic [5:0]      sextet;
	logic [6:0]      char_d;

	assign slot_free = !m_tvalid_q || m_tready;
	assign have      = busy_q || !empty;
	assign fire      = slot_free && have;
	assign pop       = fire && !busy_q;
	assign cur       = busy_q ? grp_q : head;

	always_comb begin
		case (k_q)
			2'd0:    sextet = cur.bits[23:18];
			2'd1:    sextet = cur.bits[17:12];
			2'd2:    sextet = cur.bits[11:6];
			default: sextet = cur.bits[5:0];
		endcase
		// positions past the real bytes are padding
		char_d = (k_q > cur.nbytes) ? b64e_pkg::PAD_CHAR : b64e_pkg::sextet_char(sextet);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			k_q        <= 2'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (slot_free) begin
				m_tvalid_q <= have;
			end
			if (fire) begin
				k_q    <= k_q + 2'd1;
				busy_q <= (k_q != b64e_pkg::LAST_SLOT);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= head;
		end
		if (fire) begin
			char_q <= char_d;
			last_q <= (k_q == b64e_pkg::LAST_SLOT);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tlast  = last_q;

	`B64E_ASSERT_IMPL(a_idle_slot_zero, !busy_q, k_q == 2'd0, "character slot set while idle")
	`B64E_ASSERT_NEXT(a_group_done, fire && (k_q == b64e_pkg::LAST_SLOT), !busy_q && m_tlast,
		"group did not close on its fourth character")
	`B64E_ASSERT_NEXT(a_pop_starts, pop, busy_q && (k_q == 2'd1),
		"popped group did not start at its first character")

endmodule
`default_nettype wire

// ===== rtl/core/base64_stream_encoder_top.sv =====
// channel | direction | tdata (low bit up)           | tlast
// s_*     | in        | [7:0] data_byte              | final_byte
// m_*     | out       | [6:0] char_code, [7] zero    | end_of_group
//
// a byte that completes a group is written into a two-entry group queue
// the back part sends one character per cycle when not stalled, four per group
// sustained rate is set by the output, which sends four characters for three bytes
// s_tready drops only while the group queue is full; output stalls hold m_* steady
// arst_n clears the held count, the queue and the output valid
`timescale 1ns / 1ps
`default_nettype none
module base64_stream_encoder_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tlast,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [6:0] char_code, [7] zero
	output logic            m_tlast
);

	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;
	b64e_pkg::grp_t  push_grp;
	b64e_pkg::grp_t  head;

	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.push_grp (push_grp)
	);

	b64e_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	b64e_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire
